@@ rtl/hrp_pkg.sv @@
// ----------------------------------------------------------------------------
// hrp_pkg
// Types, phase codes, event codes and keyword tables of the request line
// parser.
// ----------------------------------------------------------------------------
package hrp_pkg;

    localparam logic [3:0] PH_METHOD   = 4'd0;
    localparam logic [3:0] PH_SP1      = 4'd1;
    localparam logic [3:0] PH_SP1_MORE = 4'd2;
    localparam logic [3:0] PH_PATH     = 4'd3;
    localparam logic [3:0] PH_SP2      = 4'd4;
    localparam logic [3:0] PH_PROTO    = 4'd5;
    localparam logic [3:0] PH_ANY      = 4'd6;
    localparam logic [3:0] PH_VERSION  = 4'd7;
    localparam logic [3:0] PH_DONE     = 4'd8;
    localparam logic [3:0] PH_BAD      = 4'd9;
    localparam logic [3:0] PH_HEADERS  = 4'd10;
    localparam logic [3:0] PH_BODY     = 4'd11;
    localparam logic [3:0] PH_IGNORE   = 4'd12;

    localparam logic [2:0] EV_NONE   = 3'd0;
    localparam logic [2:0] EV_PATH   = 3'd1;
    localparam logic [2:0] EV_BODY   = 3'd2;
    localparam logic [2:0] EV_ACCEPT = 3'd3;
    localparam logic [2:0] EV_REJECT = 3'd4;

    localparam logic [1:0] M_GET    = 2'd0;
    localparam logic [1:0] M_POST   = 2'd1;
    localparam logic [1:0] M_PUT    = 2'd2;
    localparam logic [1:0] M_DELETE = 2'd3;

    localparam logic [7:0] CHR_CR = 8'h0D;
    localparam logic [7:0] CHR_LF = 8'h0A;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_message;
    } t_req;

    typedef struct packed {
        logic [2:0] event_res;
        logic [1:0] method_code;
        logic [7:0] data_byte;
        logic       last;
    } t_evt;

    typedef struct packed {
        logic [3:0] phase;
        logic [2:0] kpos;
        logic [1:0] meth;
        logic       lower;
        logic       crp;
        logic       hle;
    } t_state;

    typedef struct packed {
        t_state st;
        logic   path;
    } t_lb;

    localparam t_state ST_RESET = '{
        phase: PH_METHOD, kpos: 3'd0, meth: M_GET, lower: 1'b0, crp: 1'b0, hle: 1'b1
    };

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic logic [7:0] method_char(input logic [1:0] m, input logic [2:0] k);
        logic [7:0] r;
        r = 8'h00;
        unique case (m)
            M_GET: begin
                unique case (k)
                    3'd0:    r = "G";
                    3'd1:    r = "E";
                    3'd2:    r = "T";
                    default: r = 8'h00;
                endcase
            end
            M_POST: begin
                unique case (k)
                    3'd0:    r = "P";
                    3'd1:    r = "O";
                    3'd2:    r = "S";
                    3'd3:    r = "T";
                    default: r = 8'h00;
                endcase
            end
            M_PUT: begin
                unique case (k)
                    3'd0:    r = "P";
                    3'd1:    r = "U";
                    3'd2:    r = "T";
                    default: r = 8'h00;
                endcase
            end
            default: begin
                unique case (k)
                    3'd0:             r = "D";
                    3'd1, 3'd3, 3'd5: r = "E";
                    3'd2:             r = "L";
                    3'd4:             r = "T";
                    default:          r = 8'h00;
                endcase
            end
        endcase
        return r;
    endfunction

    function automatic logic [3:0] method_len(input logic [1:0] m);
        logic [3:0] r;
        unique case (m)
            M_GET:   r = 4'd3;
            M_POST:  r = 4'd4;
            M_PUT:   r = 4'd3;
            default: r = 4'd6;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] proto_char(input logic [2:0] k);
        logic [7:0] r;
        unique case (k)
            3'd0:    r = "H";
            3'd1:    r = "T";
            3'd2:    r = "T";
            3'd3:    r = "P";
            3'd4:    r = "/";
            3'd5:    r = "1";
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic t_lb line_byte(input t_state s, input logic [7:0] c);
        t_lb        r;
        logic [3:0] nk;
        logic [1:0] nm;
        logic       bad;
        logic [7:0] want;
        r.st = s;
        r.path = 1'b0;
        nk = {1'b0, s.kpos} + 4'd1;
        nm = s.meth;
        bad = 1'b0;
        want = proto_char(s.kpos) | ((s.kpos < 3'd4 && s.lower) ? 8'h20 : 8'h00);
        unique case (s.phase)
            PH_METHOD: begin
                if (s.kpos == 3'd0) begin
                    if (c == "G") nm = M_GET;
                    else if (c == "P") nm = M_POST;
                    else if (c == "D") nm = M_DELETE;
                    else bad = 1'b1;
                end else if (!(s.kpos < 3'd6 && c == method_char(s.meth, s.kpos))) begin
                    if (s.kpos == 3'd1 && s.meth == M_POST && c == "U") nm = M_PUT;
                    else bad = 1'b1;
                end
                if (bad) begin
                    r.st.phase = PH_BAD;
                end else begin
                    r.st.meth = nm;
                    if (nk >= method_len(nm)) begin
                        r.st.kpos = 3'd0;
                        r.st.phase = PH_SP1;
                    end else begin
                        r.st.kpos = nk[2:0];
                    end
                end
            end
            PH_SP1: r.st.phase = is_space(c) ? PH_SP1_MORE : PH_BAD;
            PH_SP1_MORE: begin
                if (!is_space(c)) begin
                    if (c == "/") begin
                        r.st.phase = PH_PATH;
                        r.path = 1'b1;
                    end else begin
                        r.st.phase = PH_BAD;
                    end
                end
            end
            PH_PATH: begin
                if (is_space(c)) r.st.phase = PH_SP2;
                else r.path = 1'b1;
            end
            PH_SP2: begin
                if (!is_space(c)) begin
                    if (c == "H" || c == "h") begin
                        r.st.lower = (c == "h");
                        r.st.kpos = 3'd1;
                        r.st.phase = PH_PROTO;
                    end else begin
                        r.st.phase = PH_BAD;
                    end
                end
            end
            PH_PROTO: begin
                if (!(s.kpos < 3'd6 && c == want)) begin
                    r.st.phase = PH_BAD;
                end else if (nk >= 4'd6) begin
                    r.st.kpos = 3'd0;
                    r.st.phase = PH_ANY;
                end else begin
                    r.st.kpos = nk[2:0];
                end
            end
            PH_ANY:     r.st.phase = (c != CHR_CR && c != CHR_LF) ? PH_VERSION : PH_BAD;
            PH_VERSION: r.st.phase = (c == "0" || c == "," || c == "1") ? PH_DONE : PH_BAD;
            PH_DONE:    r.st.phase = PH_BAD;
            PH_HEADERS: r.st.hle = 1'b0;
            default:    r.st = s;
        endcase
        return r;
    endfunction

endpackage

@@ rtl/hrp_stream_if.sv @@
// ----------------------------------------------------------------------------
// hrp_stream_if
// Valid/ready channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
interface hrp_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

@@ rtl/http_request_line_parser.sv @@
// Path: an input transaction passes through the input register, then the
// result register; the parse state updates as the byte moves between them.
// Throughput: one byte per cycle while the sink is ready, one result per byte;
// the input and result registers let a new byte enter while a result waits.
// Reset: synchronous, active low; clears both stages and returns the parser
// to idle, expecting a method.
// ----------------------------------------------------------------------------
// http_request_line_parser
// Byte-wide request line parser with header skip and body pass-through.
// ----------------------------------------------------------------------------
module http_request_line_parser (
    input  logic         i_clk,
    input  logic         i_rst_n,
    hrp_stream_if.sink   i_req,
    hrp_stream_if.source o_evt
);
    logic          stg_valid;
    hrp_pkg::t_req stg_item;
    hrp_pkg::t_evt result;
    logic          out_free;
    logic          advance;

    assign advance = stg_valid && out_free;

    hrp_in_stage u_in (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (i_req),
        .i_advance (advance),
        .o_valid   (stg_valid),
        .o_item    (stg_item)
    );

    hrp_parse_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (advance),
        .i_item   (stg_item),
        .o_result (result)
    );

    hrp_out_stage u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (advance),
        .i_result (result),
        .o_evt    (o_evt),
        .o_free   (out_free)
    );

`ifndef ASSERT_OFF
    a_data_only_on_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_evt.valid && o_evt.payload.event_res != hrp_pkg::EV_PATH
            && o_evt.payload.event_res != hrp_pkg::EV_BODY)
        |-> o_evt.payload.data_byte == 8'h00)
        else $error("data byte set on a non-byte event");

    a_method_only_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_evt.valid && o_evt.payload.event_res != hrp_pkg::EV_ACCEPT)
        |-> o_evt.payload.method_code == 2'd0)
        else $error("method code set on a non-accept event");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (stg_valid && !out_free) |-> !i_req.ready)
        else $error("input taken while the input register is held");

    a_result_follows_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> o_evt.valid)
        else $error("advanced byte produced no result");
`endif
endmodule

@@ rtl/hrp_in_stage.sv @@
// ----------------------------------------------------------------------------
// hrp_in_stage
// Input register: holds one accepted byte until the parser advances it.
// ----------------------------------------------------------------------------
module hrp_in_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    hrp_stream_if.sink        i_req,
    input  logic              i_advance,
    output logic              o_valid,
    output hrp_pkg::t_req     o_item
);
    logic          r_valid;
    hrp_pkg::t_req r_item;
    logic          take;

    assign i_req.ready = !r_valid || i_advance;
    assign take        = i_req.valid && i_req.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (take) begin
            r_valid <= 1'b1;
        end else if (i_advance) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_item <= i_req.payload;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;
endmodule

@@ rtl/hrp_parse_core.sv @@
// ----------------------------------------------------------------------------
// hrp_parse_core
// Parser state and per-byte update: request line match, header skip, body.
// ----------------------------------------------------------------------------
module hrp_parse_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  hrp_pkg::t_req     i_item,
    output hrp_pkg::t_evt     o_result
);
    hrp_pkg::t_state r_state;
    hrp_pkg::t_state n_state;
    hrp_pkg::t_lb    lb;
    hrp_pkg::t_evt   res;
    logic            ended;
    logic [7:0]      c;
    logic            eom;

    assign c   = i_item.in_byte;
    assign eom = i_item.end_of_message;

    always_comb begin
        n_state = r_state;
        res = '0;
        res.last = eom;
        ended = 1'b0;
        lb = '0;
        if (r_state.phase == hrp_pkg::PH_BODY) begin
            res.event_res = hrp_pkg::EV_BODY;
            res.data_byte = c;
        end else if (r_state.phase != hrp_pkg::PH_IGNORE) begin
            if (n_state.crp) begin
                n_state.crp = 1'b0;
                if (c == hrp_pkg::CHR_LF) begin
                    ended = 1'b1;
                end else begin
                    lb = hrp_pkg::line_byte(n_state, hrp_pkg::CHR_CR);
                    n_state = lb.st;
                end
            end
            if (!ended) begin
                if (c == hrp_pkg::CHR_CR && !eom) begin
                    n_state.crp = 1'b1;
                end else begin
                    lb = hrp_pkg::line_byte(n_state, c);
                    n_state = lb.st;
                    if (lb.path) begin
                        res.event_res = hrp_pkg::EV_PATH;
                        res.data_byte = c;
                    end
                    ended = eom;
                end
            end
            if (ended) begin
                res.data_byte = 8'h00;
                priority if (n_state.phase == hrp_pkg::PH_HEADERS) begin
                    if (n_state.hle) n_state.phase = hrp_pkg::PH_BODY;
                    n_state.hle = 1'b1;
                    res.event_res = hrp_pkg::EV_NONE;
                end else if (n_state.phase == hrp_pkg::PH_DONE) begin
                    res.method_code = n_state.meth;
                    n_state.phase = hrp_pkg::PH_HEADERS;
                    n_state.hle = 1'b1;
                    res.event_res = hrp_pkg::EV_ACCEPT;
                end else begin
                    n_state.phase = hrp_pkg::PH_IGNORE;
                    res.event_res = hrp_pkg::EV_REJECT;
                end
            end
        end
        if (eom) begin
            n_state = hrp_pkg::ST_RESET;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= hrp_pkg::ST_RESET;
        end else if (i_fire) begin
            r_state <= n_state;
        end
    end

    assign o_result = res;
endmodule

@@ rtl/hrp_out_stage.sv @@
// ----------------------------------------------------------------------------
// hrp_out_stage
// Result register: holds one event until the sink takes it.
// ----------------------------------------------------------------------------
module hrp_out_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  hrp_pkg::t_evt     i_result,
    hrp_stream_if.source      o_evt,
    output logic              o_free
);
    logic          r_valid;
    hrp_pkg::t_evt r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (o_evt.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_free        = !r_valid || o_evt.ready;
    assign o_evt.valid   = r_valid;
    assign o_evt.payload = r_result;
endmodule

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the request line parser. A short table of
// hand-picked bytes comes first, then random messages: mostly well-formed
// requests with random methods, paths, headers and bodies, some tampered
// with, cut short or pure noise. Every accepted byte runs through a local
// model of the parser and each event from the block is compared with the
// oldest expected one. Both channels idle at random, and the event side
// holds off twice for a long stretch to back the parser up.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD   = 8;
    localparam int N_DIRECTED   = 24;
    localparam int N_RANDOM     = 500;
    localparam int HOLD_CYCLES  = 90;
    localparam int CYCLE_LIMIT  = 200000;

    typedef struct {
        logic [7:0] b;
        logic       eom;
        bit         pinned;
        logic [2:0] ev;
        logic [1:0] meth;
        logic [7:0] data;
    } t_feed;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    int unsigned cycle_count = 0;
    int unsigned items_taken = 0;
    int unsigned mismatches = 0;
    bit          feed_done = 1'b0;
    bit          hold_rx = 1'b0;

    t_feed         byte_feed [$];
    hrp_pkg::t_evt events_due [$];
    logic [7:0]    msg [$];

    // parser model state
    logic [3:0]  rl_phase;
    int          kw_pos;
    logic [1:0]  verb_sel;
    bit          proto_lc;
    bit          cr_held;
    bit          hdr_blank;

    string verb_text [4] = '{"GET", "POST", "PUT", "DELETE"};
    string proto_text = "HTTP/1";
    string ver_chars = "01,";

    t_feed directed_rows [N_DIRECTED] = '{
        '{8'h00, 1'b1, 1'b1, hrp_pkg::EV_REJECT, hrp_pkg::M_GET, 8'h00},
        '{8'hFF, 1'b0, 1'b1, hrp_pkg::EV_NONE,   hrp_pkg::M_GET, 8'h00},
        '{8'h0D, 1'b0, 1'b1, hrp_pkg::EV_NONE,   hrp_pkg::M_GET, 8'h00},
        '{8'h0A, 1'b0, 1'b1, hrp_pkg::EV_REJECT, hrp_pkg::M_GET, 8'h00},
        '{8'h41, 1'b1, 1'b1, hrp_pkg::EV_NONE,   hrp_pkg::M_GET, 8'h00},
        '{"P",   1'b0, 1'b0, hrp_pkg::EV_NONE,   hrp_pkg::M_GET, 8'h00},
        '{"U",   1'b0, 1'b0, hrp_pkg::EV_NONE,   hrp_pkg::M_GET, 8'h00},
        '{"T",   1'b0, 1'b0, hrp_pkg::EV_NONE,   hrp_pkg::M_GET, 8'h00},
        '{8'h09, 1'b0, 1'b0, hrp_pkg::EV_NONE,   hrp_pkg::M_GET, 8'h00},
        '{"/",   1'b0, 1'b0, hrp_pkg::EV_NONE,   hrp_pkg::M_GET, 8'h00},
        '{8'h20, 1'b0, 1'b0, hrp_pkg::EV_NONE,   hrp_pkg::M_GET, 8'h00},
        '{"h",   1'b0, 1'b0, hrp_pkg::EV_NONE,   hrp_pkg::M_GET, 8'h00},
        '{"t",   1'b0, 1'b0, hrp_pkg::EV_NONE,   hrp_pkg::M_GET, 8'h00},
        '{"t",   1'b0, 1'b0, hrp_pkg::EV_NONE,   hrp_pkg::M_GET, 8'h00},
        '{"p",   1'b0, 1'b0, hrp_pkg::EV_NONE,   hrp_pkg::M_GET, 8'h00},
        '{"/",   1'b0, 1'b0, hrp_pkg::EV_NONE,   hrp_pkg::M_GET, 8'h00},
        '{"1",   1'b0, 1'b0, hrp_pkg::EV_NONE,   hrp_pkg::M_GET, 8'h00},
        '{8'h80, 1'b0, 1'b0, hrp_pkg::EV_NONE,   hrp_pkg::M_GET, 8'h00},
        '{",",   1'b1, 1'b1, hrp_pkg::EV_ACCEPT, hrp_pkg::M_PUT, 8'h00},
        '{"G",   1'b0, 1'b0, hrp_pkg::EV_NONE,   hrp_pkg::M_GET, 8'h00},
        '{"E",   1'b0, 1'b0, hrp_pkg::EV_NONE,   hrp_pkg::M_GET, 8'h00},
        '{"T",   1'b0, 1'b0, hrp_pkg::EV_NONE,   hrp_pkg::M_GET, 8'h00},
        '{8'h0B, 1'b0, 1'b0, hrp_pkg::EV_NONE,   hrp_pkg::M_GET, 8'h00},
        '{"/",   1'b1, 1'b1, hrp_pkg::EV_REJECT, hrp_pkg::M_GET, 8'h00}
    };

    hrp_stream_if #(.t_payload(hrp_pkg::t_req)) req_if ();
    hrp_stream_if #(.t_payload(hrp_pkg::t_evt)) evt_if ();

    http_request_line_parser dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_evt   (evt_if)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    always @(posedge i_clk) cycle_count <= cycle_count + 1;

    function automatic bit ws_byte(logic [7:0] c);
        return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic void reset_parser();
        rl_phase  = hrp_pkg::PH_METHOD;
        kw_pos    = 0;
        verb_sel  = hrp_pkg::M_GET;
        proto_lc  = 1'b0;
        cr_held   = 1'b0;
        hdr_blank = 1'b1;
    endfunction

    // Returns 1 when the byte is a path byte to report.
    function automatic bit take_line_byte(logic [7:0] c);
        int         k;
        logic [7:0] want;
        k = kw_pos;
        case (rl_phase)
            hrp_pkg::PH_METHOD: begin
                if (k == 0) begin
                    if (c == "G") verb_sel = hrp_pkg::M_GET;
                    else if (c == "P") verb_sel = hrp_pkg::M_POST;
                    else if (c == "D") verb_sel = hrp_pkg::M_DELETE;
                    else begin
                        rl_phase = hrp_pkg::PH_BAD;
                        return 1'b0;
                    end
                end else if (c != 8'(verb_text[verb_sel][k])) begin
                    if (k == 1 && verb_sel == hrp_pkg::M_POST && c == "U") begin
                        verb_sel = hrp_pkg::M_PUT;
                    end else begin
                        rl_phase = hrp_pkg::PH_BAD;
                        return 1'b0;
                    end
                end
                kw_pos = k + 1;
                if (kw_pos >= verb_text[verb_sel].len()) begin
                    kw_pos = 0;
                    rl_phase = hrp_pkg::PH_SP1;
                end
                return 1'b0;
            end
            hrp_pkg::PH_SP1: rl_phase = ws_byte(c) ? hrp_pkg::PH_SP1_MORE : hrp_pkg::PH_BAD;
            hrp_pkg::PH_SP1_MORE: begin
                if (!ws_byte(c)) begin
                    if (c == "/") begin
                        rl_phase = hrp_pkg::PH_PATH;
                        return 1'b1;
                    end
                    rl_phase = hrp_pkg::PH_BAD;
                end
            end
            hrp_pkg::PH_PATH: begin
                if (ws_byte(c)) rl_phase = hrp_pkg::PH_SP2;
                else return 1'b1;
            end
            hrp_pkg::PH_SP2: begin
                if (!ws_byte(c)) begin
                    if (c == "H" || c == "h") begin
                        proto_lc = (c == "h");
                        kw_pos = 1;
                        rl_phase = hrp_pkg::PH_PROTO;
                    end else begin
                        rl_phase = hrp_pkg::PH_BAD;
                    end
                end
            end
            hrp_pkg::PH_PROTO: begin
                want = 8'(proto_text[k]);
                if (k < 4 && proto_lc) want = want + 8'h20;
                if (c != want) begin
                    rl_phase = hrp_pkg::PH_BAD;
                end else begin
                    kw_pos = k + 1;
                    if (kw_pos >= 6) begin
                        kw_pos = 0;
                        rl_phase = hrp_pkg::PH_ANY;
                    end
                end
            end
            hrp_pkg::PH_ANY: begin
                rl_phase = (c != hrp_pkg::CHR_CR && c != hrp_pkg::CHR_LF) ?
                           hrp_pkg::PH_VERSION : hrp_pkg::PH_BAD;
            end
            hrp_pkg::PH_VERSION: begin
                rl_phase = (c == "0" || c == "," || c == "1") ?
                           hrp_pkg::PH_DONE : hrp_pkg::PH_BAD;
            end
            hrp_pkg::PH_DONE:    rl_phase = hrp_pkg::PH_BAD;
            hrp_pkg::PH_HEADERS: hdr_blank = 1'b0;
            default: ;
        endcase
        return 1'b0;
    endfunction

    function automatic hrp_pkg::t_evt predict_event(hrp_pkg::t_req r);
        hrp_pkg::t_evt e;
        bit            ended;
        logic [7:0]    c;
        c = r.in_byte;
        e = '0;
        e.event_res = hrp_pkg::EV_NONE;
        e.method_code = hrp_pkg::M_GET;
        e.last = r.end_of_message;
        ended = 1'b0;
        if (rl_phase == hrp_pkg::PH_BODY) begin
            e.event_res = hrp_pkg::EV_BODY;
            e.data_byte = c;
        end else if (rl_phase != hrp_pkg::PH_IGNORE) begin
            if (cr_held) begin
                cr_held = 1'b0;
                if (c == hrp_pkg::CHR_LF) ended = 1'b1;
                else void'(take_line_byte(hrp_pkg::CHR_CR));
            end
            if (!ended) begin
                if (c == hrp_pkg::CHR_CR && !r.end_of_message) begin
                    cr_held = 1'b1;
                end else begin
                    if (take_line_byte(c)) begin
                        e.event_res = hrp_pkg::EV_PATH;
                        e.data_byte = c;
                    end
                    if (r.end_of_message) ended = 1'b1;
                end
            end
            if (ended) begin
                e.data_byte = 8'h00;
                if (rl_phase == hrp_pkg::PH_HEADERS) begin
                    if (hdr_blank) rl_phase = hrp_pkg::PH_BODY;
                    hdr_blank = 1'b1;
                    e.event_res = hrp_pkg::EV_NONE;
                end else if (rl_phase == hrp_pkg::PH_DONE) begin
                    e.event_res = hrp_pkg::EV_ACCEPT;
                    e.method_code = verb_sel;
                    rl_phase = hrp_pkg::PH_HEADERS;
                    hdr_blank = 1'b1;
                end else begin
                    e.event_res = hrp_pkg::EV_REJECT;
                    rl_phase = hrp_pkg::PH_IGNORE;
                end
            end
        end
        if (r.end_of_message) reset_parser();
        return e;
    endfunction

    function automatic logic [7:0] ws_pick();
        return ($urandom_range(0, 3) == 0) ? 8'($urandom_range(9, 13)) : 8'h20;
    endfunction

    function automatic logic [7:0] any_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic void push_text(string s);
        for (int i = 0; i < s.len(); i++) msg.push_back(8'(s[i]));
    endfunction

    function automatic void push_crlf();
        msg.push_back(hrp_pkg::CHR_CR);
        msg.push_back(hrp_pkg::CHR_LF);
    endfunction

    function automatic void compose_message();
        int         cut;
        logic [7:0] c;
        t_feed      f;
        msg.delete();
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 8)) msg.push_back(any_byte());
        end else begin
            push_text(verb_text[$urandom_range(0, 3)]);
            repeat ($urandom_range(1, 2)) msg.push_back(ws_pick());
            msg.push_back("/");
            repeat ($urandom_range(0, 5)) msg.push_back(8'($urandom_range(8'h21, 8'hFF)));
            repeat ($urandom_range(1, 2)) msg.push_back(ws_pick());
            if ($urandom_range(0, 1) == 0) push_text("HTTP/1");
            else push_text("http/1");
            do c = any_byte(); while (c == hrp_pkg::CHR_CR || c == hrp_pkg::CHR_LF);
            msg.push_back(c);
            msg.push_back(8'(ver_chars[$urandom_range(0, 2)]));
            case ($urandom_range(0, 7))
                0: msg[$urandom_range(0, msg.size() - 1)] = any_byte();
                1: msg.push_back(8'($urandom_range(8'h21, 8'h7E)));
                default: ;
            endcase
            push_crlf();
            repeat ($urandom_range(0, 2)) begin
                repeat ($urandom_range(1, 6)) msg.push_back(any_byte());
                push_crlf();
            end
            if ($urandom_range(0, 5) != 0) push_crlf();
            repeat ($urandom_range(0, 8)) msg.push_back(any_byte());
        end
        if ($urandom_range(0, 5) == 0) begin
            cut = $urandom_range(1, msg.size());
            while (msg.size() > cut) void'(msg.pop_back());
        end
        foreach (msg[i]) begin
            f = '{msg[i], 1'b0, 1'b0, hrp_pkg::EV_NONE, hrp_pkg::M_GET, 8'h00};
            f.eom = (i == msg.size() - 1);
            byte_feed.push_back(f);
        end
    endfunction

    function automatic string evt_text(hrp_pkg::t_evt e);
        return $sformatf("ev=%0d meth=%0d data=%02h last=%0d",
                         e.event_res, e.method_code, e.data_byte, e.last);
    endfunction

    function automatic void log_failure(string what);
        if (mismatches < 10) $display("cycle %0d: %s", cycle_count, what);
        mismatches++;
    endfunction

    function automatic void check_event(hrp_pkg::t_evt want, hrp_pkg::t_evt got);
        if (got.event_res !== want.event_res || got.method_code !== want.method_code ||
            got.data_byte !== want.data_byte || got.last !== want.last) begin
            log_failure($sformatf("expected %s, got %s", evt_text(want), evt_text(got)));
        end
    endfunction

    // byte sender: bursts with random gaps
    initial begin
        t_feed         f;
        hrp_pkg::t_req r;
        hrp_pkg::t_evt p;
        int            gap;
        int            burst;
        req_if.valid = 1'b0;
        req_if.payload = '0;
        burst = 0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        while (byte_feed.size() > 0) begin
            if (burst == 0) begin
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                if (gap > 0) begin
                    req_if.valid <= 1'b0;
                    repeat (gap) @(negedge i_clk);
                end
                burst = $urandom_range(1, 24);
            end
            f = byte_feed.pop_front();
            r.in_byte = f.b;
            r.end_of_message = f.eom;
            req_if.payload <= r;
            req_if.valid <= 1'b1;
            @(posedge i_clk);
            while (req_if.ready !== 1'b1) @(posedge i_clk);
            p = predict_event(r);
            if (f.pinned) begin
                p.event_res = f.ev;
                p.method_code = f.meth;
                p.data_byte = f.data;
                p.last = f.eom;
            end
            events_due.push_back(p);
            items_taken++;
            burst--;
            @(negedge i_clk);
        end
        req_if.valid <= 1'b0;
        feed_done = 1'b1;
    end

    // event receiver: stalls follow a random mask that is re-rolled periodically
    initial begin
        int unsigned idx;
        logic [7:0]  mask;
        evt_if.ready = 1'b0;
        mask = 8'hFF;
        idx = 0;
        forever begin
            @(negedge i_clk);
            if (idx % 24 == 0) mask = ($urandom_range(0, 2) == 0) ? 8'hFF : (any_byte() | 8'h01);
            evt_if.ready <= !hold_rx && i_rst_n && mask[idx % 8];
            idx++;
        end
    end

    // long hold-offs on the event side
    initial begin
        int marks [2];
        marks = '{120, 360};
        foreach (marks[i]) begin
            wait (items_taken >= marks[i]);
            hold_rx = 1'b1;
            repeat (HOLD_CYCLES) @(posedge i_clk);
            hold_rx = 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && evt_if.valid === 1'b1 && evt_if.ready === 1'b1) begin
            if (events_due.size() == 0) log_failure({"unexpected ", evt_text(evt_if.payload)});
            else check_event(events_due.pop_front(), evt_if.payload);
        end
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("tb failed");
        $finish;
    end

    initial begin
        reset_parser();
        foreach (directed_rows[i]) byte_feed.push_back(directed_rows[i]);
        while (byte_feed.size() < N_DIRECTED + N_RANDOM) compose_message();
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        wait (feed_done);
        while (events_due.size() > 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule

@@ http_request_line_parser.f @@
rtl/hrp_pkg.sv
rtl/hrp_stream_if.sv
rtl/hrp_in_stage.sv
rtl/hrp_parse_core.sv
rtl/hrp_out_stage.sv
rtl/http_request_line_parser.sv
tb/tb.sv
